// ===== rtl/core/jce_pkg.sv =====
// jce_pkg: shared types, constants and fixed-point helpers for the 3x3 jacobi eigen unit
// used by the multiplier, the top level and the checker
`default_nettype none

package jce_pkg;

  localparam int IN_W   = 32;   // input and output field width
  localparam int ENT_W  = 36;   // working matrix entry width
  localparam int PROD_W = 72;   // shared multiplier product width
  localparam int RND_W  = 40;   // rounded q30 product width
  localparam int SUM_W  = 41;   // sum of two rounded terms

  localparam logic signed [ENT_W-1:0] ENTRY_LIMIT = 36'sh1_FFFF_FFFF;
  localparam logic signed [IN_W-1:0]  Q30_ONE     = 32'sh4000_0000;
  localparam int unsigned             MAX_SWEEPS  = 8;

  localparam logic [3:0] SWEEP_RESET = 4'd4;
  localparam logic [4:0] SHIFT_RESET = 5'd20;

  // register indexes of the configuration port
  localparam logic [1:0] REG_SWEEP_COUNT = 2'd0;
  localparam logic [1:0] REG_SKIP_SHIFT  = 2'd1;

  typedef struct packed {
    logic signed [IN_W-1:0] entry_00;
    logic signed [IN_W-1:0] entry_11;
    logic signed [IN_W-1:0] entry_22;
    logic signed [IN_W-1:0] entry_01;
    logic signed [IN_W-1:0] entry_02;
    logic signed [IN_W-1:0] entry_12;
  } in_item_t;

  typedef struct packed {
    logic signed [IN_W-1:0] eigen_0;
    logic signed [IN_W-1:0] eigen_1;
    logic signed [IN_W-1:0] eigen_2;
    logic signed [IN_W-1:0] rot_c0_r0;
    logic signed [IN_W-1:0] rot_c0_r1;
    logic signed [IN_W-1:0] rot_c0_r2;
    logic signed [IN_W-1:0] rot_c1_r0;
    logic signed [IN_W-1:0] rot_c1_r1;
    logic signed [IN_W-1:0] rot_c1_r2;
    logic signed [IN_W-1:0] rot_c2_r0;
    logic signed [IN_W-1:0] rot_c2_r1;
    logic signed [IN_W-1:0] rot_c2_r2;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] wdata;
  } cfg_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_MDD, S_MEE, S_SQ1, S_SQ1W, S_DIV1W, S_MTT, S_SQ2,
    S_SQ2W, S_DIV2W, S_MTC, S_SIN, S_UMUL, S_UACC, S_NEXT, S_DONE
  } state_t;

  // floor((p + 2^29) / 2^30)
  function automatic logic signed [RND_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) <<< 29);
    return t[RND_W+29:30];
  endfunction

  function automatic logic signed [ENT_W-1:0] sat_entry(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] lim;
    lim = SUM_W'(ENTRY_LIMIT);
    if (x > lim) return ENTRY_LIMIT;
    if (x < -lim) return -ENTRY_LIMIT;
    return x[ENT_W-1:0];
  endfunction

  function automatic logic signed [IN_W-1:0] sat_32(input logic signed [SUM_W-1:0] x);
    if (x > SUM_W'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (x < SUM_W'(32'sh8000_0000)) return 32'sh8000_0000;
    return x[IN_W-1:0];
  endfunction

  function automatic logic [ENT_W-1:0] mag(input logic signed [ENT_W-1:0] x);
    return x[ENT_W-1] ? ENT_W'(-x) : ENT_W'(x);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jce_chan_if.sv =====
// jce_chan_if: valid/ready channel carrying one payload type
// payload types come from jce_pkg
`default_nettype none

interface jce_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jce_mul.sv =====
// jce_mul: shared signed multiplier with registered product
// depends on jce_pkg for widths
`default_nettype none

module jce_mul (
  input  logic                                clk,
  input  logic signed [jce_pkg::ENT_W-1:0]    a,
  input  logic signed [jce_pkg::ENT_W-1:0]    b,
  output logic signed [jce_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/jce_isqrt.sv =====
// jce_isqrt: 64-bit floor square root, two radicand bits per cycle
// depends on nothing but the clock and reset
`default_nettype none

module jce_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done_r,
  output logic [31:0] root_r
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [35:0] r2;
  logic [35:0] trial;

  assign r2    = {rem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (r2 >= trial) begin
        rem_r  <= 34'(r2 - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= r2[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/jce_div.sv =====
// jce_div: restoring divider, 64-bit numerator by 34-bit divisor, 32 quotient bits
// the quotient must fit 32 bits; one bit per cycle
`default_nettype none

module jce_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [33:0] den,
  output logic        done_r,
  output logic [31:0] quo_r
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [31:0] lo_r;
  logic [33:0] rem_r;
  logic [33:0] den_r;
  logic [34:0] r2;

  assign r2 = {rem_r, lo_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {2'b00, num[63:32]};
      lo_r  <= num[31:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      lo_r <= {lo_r[30:0], 1'b0};
      if (r2 >= {1'b0, den_r}) begin
        rem_r <= 34'(r2 - {1'b0, den_r});
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= r2[33:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/symmetric3x3_jacobi_eigen_unit.sv =====
// symmetric3x3_jacobi_eigen_unit: cyclic jacobi eigen-decomposition of a symmetric 3x3 matrix
// uses jce_pkg, jce_chan_if, jce_mul, jce_isqrt and jce_div
//
//   channel | dir | payload                              | transfer when
//   in_ch   | in  | entry_00..entry_12, Q16.16           | valid && ready
//   out_ch  | out | eigen_0..2 Q16.16, rot_cC_rR Q2.30   | valid && ready
//   cfg_ch  | in  | index, wdata (sweep_count, skip_shift)| valid && ready, ready tied high
//
// one matrix is worked at a time; in_ch.ready is high only while no matrix is in work
// a rotation takes two square roots and two divides plus 21 passes through the
// shared multiplier; a skipped pair moves from the check straight to the next pair
// a finished result waits in the output register while the next matrix is taken
// rst_n is synchronous; configuration resets to four sweeps and a shift of twenty
`default_nettype none

module symmetric3x3_jacobi_eigen_unit (
  input  logic       clk,
  input  logic       rst_n,
  jce_chan_if.sink   in_ch,
  jce_chan_if.source out_ch,
  jce_chan_if.sink   cfg_ch
);

  localparam int EW = jce_pkg::ENT_W;
  localparam int RW = jce_pkg::IN_W;

  jce_pkg::state_t state_r, state_nxt;

  logic [3:0] sweep_cnt_r;
  logic [4:0] skip_shift_r;

  logic [1:0] pair_r;
  logic [2:0] sweep_r;
  logic [3:0] nsweep_r;
  logic [4:0] u_r;

  logic signed [EW-1:0] dg_r  [3];
  logic signed [EW-1:0] off_r [3];   // a01, a02, a12
  logic signed [RW-1:0] rot_r [3][3];

  logic [30:0]          dm_r, em_r;
  logic                 neg_r;
  logic [63:0]          sum_r;
  logic signed [RW-1:0] t_r, c_r, s_r;
  logic signed [jce_pkg::RND_W-1:0] acc_r;
  logic signed [EW-1:0] nik_r;

  logic                 out_valid_r;
  jce_pkg::out_item_t   out_data_r;

  logic                 in_fire, out_load;
  logic signed [EW-1:0] mul_a, mul_b;
  logic signed [jce_pkg::PROD_W-1:0] prod_r;
  logic                 sq_start, sq_done;
  logic [63:0]          sq_rad;
  logic [31:0]          sq_root;
  logic                 dv_start, dv_done;
  logic [63:0]          dv_num;
  logic [33:0]          dv_den;
  logic [31:0]          dv_quo;

  // index decode of the active pair
  logic [1:0] ix_i, ix_j, ix_ik, ix_jk;
  always_comb begin
    unique case (pair_r)
      2'd0:    begin ix_i = 2'd0; ix_j = 2'd1; ix_ik = 2'd1; ix_jk = 2'd2; end
      2'd1:    begin ix_i = 2'd0; ix_j = 2'd2; ix_ik = 2'd0; ix_jk = 2'd2; end
      default: begin ix_i = 2'd1; ix_j = 2'd2; ix_ik = 2'd0; ix_jk = 2'd1; end
    endcase
  end

  logic signed [EW-1:0] a_ii, a_jj, a_ij, a_ik, a_jk;
  assign a_ii = dg_r[ix_i];
  assign a_jj = dg_r[ix_j];
  assign a_ij = off_r[pair_r];
  assign a_ik = off_r[ix_ik];
  assign a_jk = off_r[ix_jk];

  // rotation update step decode
  logic [3:0] v_idx;
  logic [1:0] v_row, v_op;
  assign v_idx = 4'(u_r - 5'd5);
  assign v_row = v_idx[3:2];
  assign v_op  = v_idx[1:0];

  // skip test and rotation setup
  logic [EW:0]          thr_sum, thr;
  logic [5:0]           thr_amt;
  logic                 skip;
  logic signed [EW:0]   d_v, e_v;
  logic [EW:0]          dm_v, em_v, dem_or;
  logic [2:0]           sh_v;
  logic [EW:0]          dm_sh, em_sh;

  always_comb begin
    thr_sum = {1'b0, jce_pkg::mag(a_ii)} + {1'b0, jce_pkg::mag(a_jj)};
    thr_amt = {1'b0, skip_shift_r} + 6'd1;
    thr     = thr_sum >> thr_amt;
    skip    = {1'b0, jce_pkg::mag(a_ij)} <= thr;
    d_v     = (EW+1)'(a_jj) - (EW+1)'(a_ii);
    e_v     = (EW+1)'(a_ij) <<< 1;
    dm_v    = d_v[EW] ? (EW+1)'(-d_v) : (EW+1)'(d_v);
    em_v    = e_v[EW] ? (EW+1)'(-e_v) : (EW+1)'(e_v);
    dem_or  = dm_v | em_v;
    if (dem_or[EW:35] != '0)  sh_v = 3'd5;
    else if (dem_or[34])      sh_v = 3'd4;
    else if (dem_or[33])      sh_v = 3'd3;
    else if (dem_or[32])      sh_v = 3'd2;
    else if (dem_or[31])      sh_v = 3'd1;
    else                      sh_v = 3'd0;
    dm_sh   = dm_v >> sh_v;
    em_sh   = em_v >> sh_v;
  end

  logic [33:0] den1;
  assign den1 = {3'b000, dm_r} + {2'b00, sq_root};

  logic signed [jce_pkg::RND_W-1:0] rnd_v;
  logic signed [jce_pkg::SUM_W-1:0] acc_minus, acc_plus;
  assign rnd_v     = jce_pkg::rnd_q30(prod_r);
  assign acc_minus = jce_pkg::SUM_W'(acc_r) - jce_pkg::SUM_W'(rnd_v);
  assign acc_plus  = jce_pkg::SUM_W'(acc_r) + jce_pkg::SUM_W'(rnd_v);

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  jce_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  jce_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
    .done_r(sq_done), .root_r(sq_root)
  );

  jce_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done_r(dv_done), .quo_r(dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= jce_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    sq_start    = 1'b0;
    sq_rad      = sum_r + prod_r[63:0];
    dv_start    = 1'b0;
    dv_num      = 64'({em_r, 30'b0}) + 64'(den1 >> 1);
    dv_den      = den1;
    mul_a       = EW'(t_r);
    mul_b       = EW'(t_r);
    out_load    = 1'b0;
    unique case (state_r)
      jce_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire) state_nxt = (sweep_cnt_r == 4'd0) ? jce_pkg::S_DONE : jce_pkg::S_CHECK;
      end
      jce_pkg::S_CHECK: state_nxt = skip ? jce_pkg::S_NEXT : jce_pkg::S_MDD;
      jce_pkg::S_MDD: begin
        mul_a     = EW'({1'b0, dm_r});
        mul_b     = EW'({1'b0, dm_r});
        state_nxt = jce_pkg::S_MEE;
      end
      jce_pkg::S_MEE: begin
        mul_a     = EW'({1'b0, em_r});
        mul_b     = EW'({1'b0, em_r});
        state_nxt = jce_pkg::S_SQ1;
      end
      jce_pkg::S_SQ1: begin
        sq_start  = 1'b1;
        state_nxt = jce_pkg::S_SQ1W;
      end
      jce_pkg::S_SQ1W: begin
        if (sq_done) begin
          dv_start  = 1'b1;
          state_nxt = jce_pkg::S_DIV1W;
        end
      end
      jce_pkg::S_DIV1W: if (dv_done) state_nxt = jce_pkg::S_MTT;
      jce_pkg::S_MTT:   state_nxt = jce_pkg::S_SQ2;
      jce_pkg::S_SQ2: begin
        sq_start  = 1'b1;
        sq_rad    = (64'd1 << 60) + prod_r[63:0];
        state_nxt = jce_pkg::S_SQ2W;
      end
      jce_pkg::S_SQ2W: begin
        dv_num = (64'd1 << 60) + 64'(sq_root >> 1);
        dv_den = {2'b00, sq_root};
        if (sq_done) begin
          dv_start  = 1'b1;
          state_nxt = jce_pkg::S_DIV2W;
        end
      end
      jce_pkg::S_DIV2W: if (dv_done) state_nxt = jce_pkg::S_MTC;
      jce_pkg::S_MTC: begin
        mul_b     = EW'(c_r);
        state_nxt = jce_pkg::S_SIN;
      end
      jce_pkg::S_SIN: state_nxt = jce_pkg::S_UMUL;
      jce_pkg::S_UMUL: begin
        case (u_r)
          5'd0: begin mul_a = EW'(c_r); mul_b = a_ik; end
          5'd1: begin mul_a = EW'(s_r); mul_b = a_jk; end
          5'd2: begin mul_a = EW'(c_r); mul_b = a_jk; end
          5'd3: begin mul_a = EW'(s_r); mul_b = a_ik; end
          5'd4: begin mul_a = EW'(t_r); mul_b = a_ij; end
          default: begin
            case (v_op)
              2'd0: begin mul_a = EW'(c_r); mul_b = EW'(rot_r[ix_i][v_row]); end
              2'd1: begin mul_a = EW'(s_r); mul_b = EW'(rot_r[ix_j][v_row]); end
              2'd2: begin mul_a = EW'(s_r); mul_b = EW'(rot_r[ix_i][v_row]); end
              default: begin mul_a = EW'(c_r); mul_b = EW'(rot_r[ix_j][v_row]); end
            endcase
          end
        endcase
        state_nxt = jce_pkg::S_UACC;
      end
      jce_pkg::S_UACC: state_nxt = (u_r == 5'd16) ? jce_pkg::S_NEXT : jce_pkg::S_UMUL;
      jce_pkg::S_NEXT: begin
        if (pair_r == 2'd2 && ({1'b0, sweep_r} + 4'd1) == nsweep_r) state_nxt = jce_pkg::S_DONE;
        else                                                         state_nxt = jce_pkg::S_CHECK;
      end
      jce_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = jce_pkg::S_IDLE;
        end
      end
      default: state_nxt = jce_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r  <= jce_pkg::SWEEP_RESET;
      skip_shift_r <= jce_pkg::SHIFT_RESET;
      out_valid_r  <= 1'b0;
      pair_r       <= '0;
      sweep_r      <= '0;
      nsweep_r     <= '0;
      u_r          <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.index)
          jce_pkg::REG_SWEEP_COUNT: sweep_cnt_r  <= cfg_ch.data.wdata[3:0];
          jce_pkg::REG_SKIP_SHIFT:  skip_shift_r <= cfg_ch.data.wdata[4:0];
          default: ;
        endcase
      end
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (in_fire) begin
        pair_r   <= '0;
        sweep_r  <= '0;
        nsweep_r <= (sweep_cnt_r > 4'(jce_pkg::MAX_SWEEPS)) ? 4'(jce_pkg::MAX_SWEEPS)
                                                            : sweep_cnt_r;
      end
      if (state_r == jce_pkg::S_SIN) u_r <= '0;
      if (state_r == jce_pkg::S_UACC) u_r <= u_r + 5'd1;
      if (state_r == jce_pkg::S_NEXT) begin
        if (pair_r == 2'd2) begin
          pair_r  <= '0;
          sweep_r <= sweep_r + 3'd1;
        end else begin
          pair_r <= pair_r + 2'd1;
        end
      end
    end
  end

  // matrix and rotation datapath
  always_ff @(posedge clk) begin
    case (state_r)
      jce_pkg::S_IDLE: begin
        if (in_fire) begin
          dg_r[0]  <= EW'(in_ch.data.entry_00);
          dg_r[1]  <= EW'(in_ch.data.entry_11);
          dg_r[2]  <= EW'(in_ch.data.entry_22);
          off_r[0] <= EW'(in_ch.data.entry_01);
          off_r[1] <= EW'(in_ch.data.entry_02);
          off_r[2] <= EW'(in_ch.data.entry_12);
          for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
              rot_r[c][r] <= (c == r) ? jce_pkg::Q30_ONE : '0;
        end
      end
      jce_pkg::S_CHECK: begin
        dm_r  <= dm_sh[30:0];
        em_r  <= em_sh[30:0];
        neg_r <= (d_v != '0) && (d_v[EW] != e_v[EW]);
      end
      jce_pkg::S_MEE: sum_r <= prod_r[63:0];
      jce_pkg::S_DIV1W: if (dv_done) t_r <= neg_r ? -$signed(dv_quo) : $signed(dv_quo);
      jce_pkg::S_DIV2W: if (dv_done) c_r <= $signed(dv_quo);
      jce_pkg::S_SIN:   s_r <= rnd_v[RW-1:0];
      jce_pkg::S_UACC: begin
        case (u_r)
          5'd0, 5'd2: acc_r <= rnd_v;
          5'd1:       nik_r <= jce_pkg::sat_entry(acc_minus);
          5'd3: begin
            off_r[ix_ik] <= nik_r;
            off_r[ix_jk] <= jce_pkg::sat_entry(acc_plus);
          end
          5'd4: begin
            dg_r[ix_i]    <= jce_pkg::sat_entry(jce_pkg::SUM_W'(a_ii) - jce_pkg::SUM_W'(rnd_v));
            dg_r[ix_j]    <= jce_pkg::sat_entry(jce_pkg::SUM_W'(a_jj) + jce_pkg::SUM_W'(rnd_v));
            off_r[pair_r] <= '0;
          end
          default: begin
            case (v_op)
              2'd0, 2'd2: acc_r <= rnd_v;
              2'd1:       nik_r <= EW'(jce_pkg::sat_32(acc_minus));
              default: begin
                rot_r[ix_i][v_row] <= nik_r[RW-1:0];
                rot_r[ix_j][v_row] <= jce_pkg::sat_32(acc_plus);
              end
            endcase
          end
        endcase
      end
      jce_pkg::S_DONE: begin
        if (out_load) begin
          out_data_r.eigen_0   <= jce_pkg::sat_32(jce_pkg::SUM_W'(dg_r[0]));
          out_data_r.eigen_1   <= jce_pkg::sat_32(jce_pkg::SUM_W'(dg_r[1]));
          out_data_r.eigen_2   <= jce_pkg::sat_32(jce_pkg::SUM_W'(dg_r[2]));
          out_data_r.rot_c0_r0 <= rot_r[0][0];
          out_data_r.rot_c0_r1 <= rot_r[0][1];
          out_data_r.rot_c0_r2 <= rot_r[0][2];
          out_data_r.rot_c1_r0 <= rot_r[1][0];
          out_data_r.rot_c1_r1 <= rot_r[1][1];
          out_data_r.rot_c1_r2 <= rot_r[1][2];
          out_data_r.rot_c2_r0 <= rot_r[2][0];
          out_data_r.rot_c2_r1 <= rot_r[2][1];
          out_data_r.rot_c2_r2 <= rot_r[2][2];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/jce_checker.sv =====
// jce_checker: port-level assertions for the jacobi eigen unit
// bound to symmetric3x3_jacobi_eigen_unit; uses jce_pkg for the result type
`default_nettype none

module jce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input jce_pkg::out_item_t out_data
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // after a matrix transfer the unit is busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  // a result never shows up in the cycle right after a matrix transfer
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early after input transfer");

endmodule

bind symmetric3x3_jacobi_eigen_unit jce_checker u_jce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
